// File: rtl/cia_pkg.sv
package cia_pkg;

  // Operand and result width of the stream words.
  localparam int unsigned WORD_W = 32;
  // Width of the exact add, subtract and multiply result.
  localparam int unsigned WIDE_W = 64;
  // Default width at which add, subtract and multiply wrap.
  localparam int unsigned DATA_WIDTH_DEF = 32;
  // Magnitude bits of a non-negative dividend or positive divisor.
  localparam int unsigned DIV_BITS = 31;
  // Packed stream widths.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;
  // Lowest bits above which an in-range value only repeats its sign.
  localparam int unsigned BYTE_SIGN_LSB = 7;
  localparam int unsigned HALF_SIGN_LSB = 15;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_I8   = 2'd0,
    KIND_I16  = 2'd1,
    KIND_I32  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    TRAP_NONE        = 3'd0,
    TRAP_RANGE       = 3'd1,
    TRAP_DIV_ZERO    = 3'd2,
    TRAP_NEG_DIVISOR = 3'd3,
    TRAP_BAD_KIND    = 3'd4
  } trap_e;

  // Control and side data that travel with each word through the divider.
  typedef struct packed {
    logic                valid;
    logic                is_div;
    logic                is_mod;
    logic                neg;
    trap_e               trap;
    logic [WORD_W-1:0]   result;
  } ctl_t;

endpackage

// File: rtl/cia_arith.sv
module cia_arith #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [2:0]                         operation_i,
  input  logic [1:0]                         int_kind_i,
  input  logic [cia_pkg::WORD_W-1:0]         operand_a_i,
  input  logic [cia_pkg::WORD_W-1:0]         operand_b_i,
  output cia_pkg::ctl_t                      ctl_o,
  output logic [cia_pkg::DIV_BITS-1:0]       dividend_o,
  output logic [cia_pkg::DIV_BITS-1:0]       divisor_o
);
  import cia_pkg::*;

  logic                     valid_q;
  logic [2:0]               op_q;
  logic [1:0]               kind_q;
  logic [WORD_W-1:0]        a_q, b_q;
  logic [DATA_WIDTH-1:0]    wrap_d, wrap_q;
  logic signed [WIDE_W-1:0] exact;
  logic signed [WIDE_W-1:0] ext;
  logic                     fits8, fits16;
  ctl_t                     ctl_d, ctl_q;
  logic [DIV_BITS-1:0]      dvd_d, dvd_q, dvs_q;

  // First stage: exact result of add, subtract or multiply, wrapped.
  always_comb begin
    unique case (operation_i)
      OP_ADD:  exact = WIDE_W'(signed'(operand_a_i)) + WIDE_W'(signed'(operand_b_i));
      OP_SUB:  exact = WIDE_W'(signed'(operand_a_i)) - WIDE_W'(signed'(operand_b_i));
      default: exact = WIDE_W'(signed'(operand_a_i)) * WIDE_W'(signed'(operand_b_i));
    endcase
    wrap_d = exact[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= operation_i;
      kind_q <= int_kind_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      wrap_q <= wrap_d;
    end
  end

  // Second stage: range check, trap decision and divider set-up.
  always_comb begin
    ext    = WIDE_W'(signed'(wrap_q));
    fits8  = (ext[WIDE_W-1:BYTE_SIGN_LSB] == '0) || (&ext[WIDE_W-1:BYTE_SIGN_LSB]);
    fits16 = (ext[WIDE_W-1:HALF_SIGN_LSB] == '0) || (&ext[WIDE_W-1:HALF_SIGN_LSB]);
    ctl_d        = '0;
    ctl_d.valid  = valid_q;
    ctl_d.is_div = (op_q == OP_DIV);
    ctl_d.is_mod = (op_q == OP_MOD);
    ctl_d.neg    = a_q[WORD_W-1];
    ctl_d.result = ext[WORD_W-1:0];
    ctl_d.trap   = TRAP_NONE;
    unique case (op_q)
      OP_ADD, OP_SUB, OP_MUL: begin
        unique case (kind_q)
          KIND_I8:  ctl_d.trap = fits8  ? TRAP_NONE : TRAP_RANGE;
          KIND_I16: ctl_d.trap = fits16 ? TRAP_NONE : TRAP_RANGE;
          KIND_I32: ctl_d.trap = TRAP_NONE;
          default:  ctl_d.trap = TRAP_BAD_KIND;
        endcase
      end
      OP_DIV, OP_MOD: begin
        if (b_q == '0) begin
          ctl_d.trap = TRAP_DIV_ZERO;
        end else if (b_q[WORD_W-1]) begin
          ctl_d.trap = TRAP_NEG_DIVISOR;
        end
      end
      default: ctl_d.trap = TRAP_BAD_KIND;
    endcase
    // A negative dividend x is divided as -x-1, which is its complement.
    dvd_d = a_q[WORD_W-1] ? ~a_q[DIV_BITS-1:0] : a_q[DIV_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q <= dvd_d;
      dvs_q <= b_q[DIV_BITS-1:0];
    end
  end

  assign ctl_o      = ctl_q;
  assign dividend_o = dvd_q;
  assign divisor_o  = dvs_q;

endmodule

// File: rtl/cia_div.sv
module cia_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  cia_pkg::ctl_t                 ctl_i,
  input  logic [cia_pkg::DIV_BITS-1:0]  dividend_i,
  input  logic [cia_pkg::DIV_BITS-1:0]  divisor_i,
  output cia_pkg::ctl_t                 ctl_o,
  output logic [cia_pkg::DIV_BITS-1:0]  quotient_o,
  output logic [cia_pkg::DIV_BITS-1:0]  remainder_o,
  output logic [cia_pkg::DIV_BITS-1:0]  divisor_o
);
  import cia_pkg::*;

  ctl_t                ctl_q [DIV_BITS];
  logic [DIV_BITS-1:0] rem_q [DIV_BITS];
  logic [DIV_BITS-1:0] dq_q  [DIV_BITS];
  logic [DIV_BITS-1:0] dvs_q [DIV_BITS];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    ctl_t                ctl_in;
    logic [DIV_BITS-1:0] rem_in, dq_in, dvs_in, rem_d, dq_d;
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS+1:0] diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    always_comb begin
      trial = {rem_in, dq_in[DIV_BITS-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_in};
      ge    = ~diff[DIV_BITS+1];
      rem_d = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      dq_d  = {dq_in[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        dq_q[k]  <= dq_d;
        dvs_q[k] <= dvs_in;
      end
    end
  end

  assign ctl_o       = ctl_q[DIV_BITS-1];
  assign quotient_o  = dq_q[DIV_BITS-1];
  assign remainder_o = rem_q[DIV_BITS-1];
  assign divisor_o   = dvs_q[DIV_BITS-1];

endmodule

// File: rtl/checked_integer_alu.sv
// Checked integer ALU: one operation on two signed 32-bit operands per word.
// Input stream: s_axis_tdata carries operation, int_kind, operand_a and
// operand_b; each accepted word gives exactly one output word on m_axis_tdata
// with result_value and trap_code, in order.
// Add, subtract and multiply wrap to DATA_WIDTH bits and are range-checked
// against the integer kind; divide and modulo are floored and trap on a zero
// or negative divisor. Any trap returns a zero result.
// The pipeline has two arithmetic stages, 31 divider stages (one quotient
// bit per stage) and the output register. Every word takes the same path,
// so a new word is accepted in every cycle unless the output is stalled.
// Reset empties the pipeline; no word is in flight afterwards.
// When the receiver stalls with a word waiting at the output, the whole
// pipeline holds and s_axis_tready falls; when the output register is empty
// or being read, the pipeline moves and bubbles pass through.
module checked_integer_alu #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation[2:0], int_kind[4:3], operand_a[36:5], operand_b[68:37], zero
  input  logic [cia_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_value[31:0], trap_code[34:32], zero
  output logic [cia_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import cia_pkg::*;

  logic                en;
  ctl_t                ar_ctl, dv_ctl;
  logic [DIV_BITS-1:0] ar_dvd, ar_dvs, dv_q, dv_r, dv_dvs;
  logic [WORD_W-1:0]   res_d, res_q;
  trap_e               trap_q;
  logic                out_valid_q;

  // The pipeline advances unless a finished word waits on a stalled receiver.
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  cia_arith #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .operation_i (s_axis_tdata[2:0]),
    .int_kind_i  (s_axis_tdata[4:3]),
    .operand_a_i (s_axis_tdata[36:5]),
    .operand_b_i (s_axis_tdata[68:37]),
    .ctl_o       (ar_ctl),
    .dividend_o  (ar_dvd),
    .divisor_o   (ar_dvs)
  );

  cia_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ar_ctl),
    .dividend_i  (ar_dvd),
    .divisor_i   (ar_dvs),
    .ctl_o       (dv_ctl),
    .quotient_o  (dv_q),
    .remainder_o (dv_r),
    .divisor_o   (dv_dvs)
  );

  // Floored correction for negative dividends, then zero on any trap.
  always_comb begin
    if (dv_ctl.is_div) begin
      res_d = dv_ctl.neg ? ~{1'b0, dv_q} : {1'b0, dv_q};
    end else if (dv_ctl.is_mod) begin
      res_d = dv_ctl.neg ? ({1'b0, dv_dvs} - WORD_W'(1) - {1'b0, dv_r}) : {1'b0, dv_r};
    end else begin
      res_d = dv_ctl.result;
    end
    if (dv_ctl.trap != TRAP_NONE) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      trap_q <= dv_ctl.trap;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, trap_q, res_q};

  // A trapped word always carries a zero result.
  a_trap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[34:32] != TRAP_NONE) |-> m_axis_tdata[31:0] == '0)
    else $error("trapped word with non-zero result");

  // A word waiting on a stalled receiver stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed during stall");

  // Nothing is accepted while the output is blocked.
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

endmodule

// File: tb/checked_integer_alu_test.sv
module checked_integer_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cia_pkg::*;

  // One expected result word: value and trap code.
  typedef struct packed {
    logic [31:0] value;
    trap_e       trap;
  } alu_result_t;

  // Holds the predicted results in order and checks each output word.
  class alu_scoreboard;
    alu_result_t pending[$];
    int unsigned errors;

    // Floored, checked arithmetic of one word.
    function alu_result_t compute(logic [2:0] op, logic [1:0] kind,
                                  logic [31:0] a, logic [31:0] b);
      alu_result_t r;
      longint sa, sb, w, q;
      logic [63:0] wide;
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      r.value = '0;
      r.trap = TRAP_NONE;
      if (op == OP_ADD || op == OP_SUB || op == OP_MUL) begin
        if (op == OP_ADD) wide = sa + sb;
        else if (op == OP_SUB) wide = sa - sb;
        else wide = sa * sb;
        w = longint'($signed(wide[31:0]));
        if (kind == KIND_I8 && (w < -128 || w > 127)) r.trap = TRAP_RANGE;
        else if (kind == KIND_I16 && (w < -32768 || w > 32767)) r.trap = TRAP_RANGE;
        else if (kind == KIND_BAD) r.trap = TRAP_BAD_KIND;
        r.value = wide[31:0];
      end else if (op == OP_DIV || op == OP_MOD) begin
        if (sb == 0) r.trap = TRAP_DIV_ZERO;
        else if (sb < 0) r.trap = TRAP_NEG_DIVISOR;
        else begin
          if (sa >= 0) q = (op == OP_DIV) ? sa / sb : sa % sb;
          else if (op == OP_DIV) q = -((-sa - 1) / sb + 1);
          else q = sb - 1 - ((-sa - 1) % sb);
          r.value = q[31:0];
        end
      end else begin
        r.trap = TRAP_BAD_KIND;
      end
      if (r.trap != TRAP_NONE) r.value = '0;
      return r;
    endfunction

    function void note_input(logic [IN_TDATA_W-1:0] d);
      pending.push_back(compute(d[2:0], d[4:3], d[36:5], d[68:37]));
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      alu_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, d);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (d[31:0] !== exp_r.value) begin
        $display("%0t: result_value expected %h actual %h", $realtime, exp_r.value, d[31:0]);
        errors++;
      end
      if (d[34:32] !== exp_r.trap) begin
        $display("%0t: trap_code expected %0d actual %0d", $realtime, exp_r.trap, d[34:32]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  alu_scoreboard board = new();
  bit stimulus_done = 1'b0;
  int unsigned stall_left = 0;

  checked_integer_alu DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offers one word and holds it until accepted.
  task automatic send_word(logic [2:0] op, logic [1:0] kind, logic [31:0] a, logic [31:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, b, a, kind, op};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(s_axis_tdata);
  endtask

  task automatic pause(int unsigned n);
    if (n == 0) return;
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Operand mix: corners, small values and full random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(2);
      1: return 32'h7fff_ffff - $urandom_range(2);
      2: return $urandom_range(300) - 150;
      3: return $urandom_range(70000) - 35000;
      4: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: stalls of random length, checking every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if (stall_left == 0) begin
        m_axis_tready <= 1'b1;
        stall_left <= ($urandom_range(99) < 30) ? gap_len() : 0;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end
    end
  end

  // Directed corners, then random words.
  initial begin
    int unsigned i, p;
    logic [2:0] op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(OP_ADD, KIND_I8, 32'd127, 32'd0);
    send_word(OP_ADD, KIND_I8, 32'd127, 32'd1);
    send_word(OP_SUB, KIND_I8, -32'sd128, 32'd0);
    send_word(OP_SUB, KIND_I8, -32'sd128, 32'd1);
    send_word(OP_ADD, KIND_I16, 32'd32767, 32'd1);
    send_word(OP_SUB, KIND_I16, -32'sd32768, 32'd0);
    send_word(OP_ADD, KIND_I32, 32'h7fff_ffff, 32'd1);
    send_word(OP_MUL, KIND_I32, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_MUL, KIND_I16, 32'd181, 32'd181);
    send_word(OP_MUL, KIND_BAD, 32'd1, 32'd1);
    send_word(OP_DIV, KIND_BAD, 32'd7, 32'd0);
    send_word(OP_MOD, KIND_I8, 32'd7, 32'hffff_fff9);
    send_word(OP_DIV, KIND_I8, -32'sd7, 32'd2);
    send_word(OP_MOD, KIND_I8, -32'sd7, 32'd2);
    send_word(OP_DIV, KIND_I32, 32'h8000_0000, 32'd1);
    send_word(OP_MOD, KIND_I32, 32'h8000_0000, 32'h7fff_ffff);
    send_word(OP_DIV, KIND_I32, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(OP_MOD, KIND_I16, 32'd6, 32'd16);
    send_word(3'd5, KIND_I8, 32'd1, 32'd1);
    send_word(3'd6, KIND_I16, 32'd1, 32'd1);
    send_word(3'd7, KIND_BAD, 32'hffff_ffff, 32'hffff_ffff);
    for (i = 0; i < 1300; i++) begin
      pause(gap_len());
      p = $urandom_range(99);
      op = (p < 94) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
      send_word(op, 2'($urandom_range(3)), pick_operand(), pick_operand());
    end
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Drain the pipeline, then give the verdict.
  initial begin
    wait (stimulus_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Timeout well above the slowest correct run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: filelist.f
rtl/cia_pkg.sv
rtl/cia_arith.sv
rtl/cia_div.sv
rtl/checked_integer_alu.sv
tb/checked_integer_alu_test.sv
